// ===== hdl/sdmd_pkg.sv =====
// ============================================================================
// sdmd_pkg
// Shared widths, register indexes and reset values of the sigma-delta
// motion detector.
// ============================================================================
package sdmd_pkg;

    localparam int PIX_W  = 8;
    localparam int IDX_W  = 18;
    localparam int AMP_W  = 4;
    localparam int PROD_W = AMP_W + PIX_W;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_AMPLIFICATION    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VARIANCE_FLOOR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VARIANCE_CEILING = 2'd2;

    localparam logic [AMP_W-1:0] AMPLIFICATION_RST    = 4'd2;
    localparam logic [PIX_W-1:0] VARIANCE_FLOOR_RST   = 8'd1;
    localparam logic [PIX_W-1:0] VARIANCE_CEILING_RST = 8'd254;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // one memory word: background variance over background mean
    typedef struct packed {
        logic [PIX_W-1:0] variance;
        logic [PIX_W-1:0] mean;
    } bg_word_t;

endpackage

// ===== hdl/sigma_delta_motion_detect.sv =====
// ============================================================================
// sigma_delta_motion_detect
// Sigma-delta background subtraction on a grey pixel stream.
// ============================================================================
// The block accepts one pixel word per clock unless the output stalls and
// returns one result word per pixel, in order, via the stage 1 and output
// registers. The per-pixel background mean and variance live in one memory
// of FRAME_PIXELS words (16 bits each) with a registered read port and a
// write port; the read happens at acceptance and the update is written back
// as the pixel leaves stage 1, so the memory's single read and single write
// per cycle set that rate. A pixel whose position was updated by the word
// just before it takes the updated value from a forwarding register instead
// of the memory. The memory is not cleared after reset: every position must
// first see a word with init set before a plain update reads it. A
// pixel_index at or above FRAME_PIXELS leaves the memory alone and returns
// moving 0, difference 0. Configuration must be written through the cfg
// port only while the stream is idle; the block does not enforce it.
// ============================================================================
module sigma_delta_motion_detect
    import sdmd_pkg::*;
#(
    parameter int FRAME_PIXELS = 262144
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] pixel, [25:8] pixel_index, rest zero
    input  logic                  s_tuser,   // [0] init

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] difference
    output logic                  m_tuser    // [0] moving
);

    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    // compare width wide enough to hold FRAME_PIXELS itself and the index
    localparam int CW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [AMP_W-1:0] amplification_reg;
    logic [PIX_W-1:0] variance_floor_reg;
    logic [PIX_W-1:0] variance_ceiling_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amplification_reg    <= AMPLIFICATION_RST;
            variance_floor_reg   <= VARIANCE_FLOOR_RST;
            variance_ceiling_reg <= VARIANCE_CEILING_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_AMPLIFICATION:    amplification_reg    <= cfg_wdata[AMP_W-1:0];
                REG_VARIANCE_FLOOR:   variance_floor_reg   <= cfg_wdata;
                REG_VARIANCE_CEILING: variance_ceiling_reg <= cfg_wdata;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] in_pixel;
    logic [CW-1:0]    in_index;
    logic             in_range;
    logic [AW-1:0]    in_addr;
    logic             s_accept;

    assign in_pixel = s_tdata[PIX_W-1:0];
    assign in_index = CW'(s_tdata[PIX_W +: IDX_W]);
    assign in_range = in_index < CW'(FRAME_PIXELS);
    assign in_addr  = in_index[AW-1:0];

    // ------------------------------------------------------------------
    // stage 1: item whose background word is being read
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic             s1_init_reg;
    logic             s1_range_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_advance;

    logic             m_valid_reg;
    logic [PIX_W-1:0] m_diff_reg;
    logic             m_moving_reg;

    // stage 1 moves on whenever the output register is free or being taken
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // background memory
    // ------------------------------------------------------------------
    bg_word_t bg_mem [0:FRAME_PIXELS-1];
    bg_word_t rd_word_reg;
    logic     wr_en;
    bg_word_t wr_word;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bg_mem[s1_addr_reg] <= wr_word;
        end
        if (s_accept) begin
            rd_word_reg <= bg_mem[in_addr];
        end
    end

    // forward the word written at the same edge as the read of the same entry
    logic     fwd_sel_reg;
    bg_word_t fwd_word_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg <= in_pixel;
            s1_init_reg  <= s_tuser;
            s1_range_reg <= in_range;
            s1_addr_reg  <= in_addr;
            fwd_sel_reg  <= wr_en && (s1_addr_reg == in_addr);
            fwd_word_reg <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // update: mean step, difference, variance step and clamp
    // ------------------------------------------------------------------
    bg_word_t          cur_word;
    logic [PIX_W-1:0]  mean_step;
    logic [PIX_W-1:0]  diff_step;
    logic [PROD_W-1:0] target;
    logic [PIX_W-1:0]  var_step;
    logic [PIX_W-1:0]  var_clamp;
    logic [PIX_W-1:0]  mean_next;
    logic [PIX_W-1:0]  var_next;
    logic [PIX_W-1:0]  diff_next;
    logic              moving_next;

    assign cur_word = fwd_sel_reg ? fwd_word_reg : rd_word_reg;

    always_comb begin
        // move the mean one grey level toward the pixel
        if (cur_word.mean < s1_pixel_reg) begin
            mean_step = cur_word.mean + 8'd1;
        end else if (cur_word.mean > s1_pixel_reg) begin
            mean_step = cur_word.mean - 8'd1;
        end else begin
            mean_step = cur_word.mean;
        end

        diff_step = (mean_step > s1_pixel_reg) ? mean_step - s1_pixel_reg
                                               : s1_pixel_reg - mean_step;
        target    = PROD_W'(amplification_reg) * PROD_W'(diff_step);

        // move the variance one step toward the target, saturate at full scale
        if (PROD_W'(cur_word.variance) < target) begin
            var_step = (cur_word.variance == PIX_MAX) ? PIX_MAX
                                                      : cur_word.variance + 8'd1;
        end else if (PROD_W'(cur_word.variance) > target) begin
            var_step = cur_word.variance - 8'd1;
        end else begin
            var_step = cur_word.variance;
        end

        // ceiling first, floor last so the floor wins
        var_clamp = (var_step > variance_ceiling_reg) ? variance_ceiling_reg : var_step;
        if (var_clamp < variance_floor_reg) begin
            var_clamp = variance_floor_reg;
        end

        if (s1_init_reg) begin
            mean_next = s1_pixel_reg;
            var_next  = variance_floor_reg;
            diff_next = '0;
        end else begin
            mean_next = mean_step;
            var_next  = var_clamp;
            diff_next = diff_step;
        end

        moving_next = diff_next >= var_next;
    end

    assign wr_en            = s1_advance && s1_range_reg;
    assign wr_word.mean     = mean_next;
    assign wr_word.variance = var_next;

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            // out-of-frame position: report no motion and zero difference
            m_diff_reg   <= s1_range_reg ? diff_next : '0;
            m_moving_reg <= s1_range_reg && moving_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_diff_reg;
    assign m_tuser  = m_moving_reg;

endmodule

// ===== hdl/sdmd_checker.sv =====
// ============================================================================
// sdmd_checker
// Port-level checks of the sigma-delta motion detector.
// ============================================================================
module sdmd_checker
    import sdmd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // no result word right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // with the result side empty the input side never stalls
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

    // an init word that leaves stage 1 while the result side is ready reaches the output with zero difference
    a_init_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) ##1 m_tready |=> m_tvalid && (m_tdata == '0))
        else $error("init word did not return zero difference in time");

endmodule

bind sigma_delta_motion_detect sdmd_checker u_sdmd_checker (.*);
